### hw/rtl/imf_pkg.sv
// ----------------------------------------------------------------------------
// imf_pkg
// Shared widths, constants, types and fixed-point helpers of the x-direction
// ideal-MHD flux pipeline.
// ----------------------------------------------------------------------------
package imf_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int WORD_BITS   = 32;
    localparam int RHO_W       = 31;
    localparam int GAMMA_W     = 18;
    localparam int Q_BITS      = 32;
    localparam int DIV_NUM_W   = 2 * Q_BITS;
    localparam int PROD_W      = 2 * WORD_BITS - FRAC_BITS;
    localparam int PRE_STAGES  = 3;
    localparam int POST_STAGES = 7;
    localparam int LATENCY     = PRE_STAGES + Q_BITS + POST_STAGES;

    localparam logic [GAMMA_W-1:0] GAMMA_RESET = GAMMA_W'(109227);
    localparam longint ONE   = longint'(1) <<< FRAC_BITS;
    localparam longint W_MAX = (longint'(1) <<< (WORD_BITS - 1)) - 1;
    localparam longint W_MIN = -W_MAX - 1;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [PROD_W-1:0]    prod_t;

    typedef struct packed {
        word_t val;
        logic  sat;
    } clip_t;

    // side data that travels alongside the quotient pipelines
    typedef struct packed {
        logic       rho_zero;
        logic       ke_ovf;
        logic [2:0] vel_ovf;
        logic [2:0] vel_neg;
        word_t      pm;
        logic       sat;
        word_t      en;
        word_t      mx;
        word_t      bx;
        word_t      by;
        word_t      bz;
        logic       last;
    } carry_t;

    function automatic clip_t clip_w(input longint x);
        clip_t r;
        if (x > W_MAX) begin
            r.val = word_t'(W_MAX);
            r.sat = 1'b1;
        end else if (x < W_MIN) begin
            r.val = word_t'(W_MIN);
            r.sat = 1'b1;
        end else begin
            r.val = word_t'(x);
            r.sat = 1'b0;
        end
        return r;
    endfunction

    // product with floor rounding of the dropped fraction
    function automatic longint fmul(input word_t a, input word_t b);
        longint p;
        p = longint'(a) * longint'(b);
        return p >>> FRAC_BITS;
    endfunction

    function automatic logic [WORD_BITS-1:0] mag(input word_t a);
        logic [WORD_BITS-1:0] m;
        m = a[WORD_BITS-1] ? (~a + 1'b1) : a;
        return m;
    endfunction

endpackage

### hw/rtl/imf_prep.sv
// ----------------------------------------------------------------------------
// imf_prep
// Input register, squares of momenta and field, then sums, magnetic half
// term and divider operands with overflow pre-checks.
// ----------------------------------------------------------------------------
module imf_prep
    import imf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_vld,
    input  logic [RHO_W-1:0]     density,
    input  word_t                mom_x,
    input  word_t                mom_y,
    input  word_t                mom_z,
    input  word_t                total_energy,
    input  word_t                field_x,
    input  word_t                field_y,
    input  word_t                field_z,
    input  logic                 last_cell,
    output logic                 out_vld,
    output carry_t               carry,
    output logic [DIV_NUM_W-1:0] num_u,
    output logic [DIV_NUM_W-1:0] num_v,
    output logic [DIV_NUM_W-1:0] num_w,
    output logic [DIV_NUM_W-1:0] num_k,
    output logic [RHO_W-1:0]     den
);

    typedef struct packed {
        logic [RHO_W-1:0] rho;
        word_t            mx;
        word_t            my;
        word_t            mz;
        word_t            en;
        word_t            bx;
        word_t            by;
        word_t            bz;
        logic             last;
    } item_t;

    typedef struct packed {
        item_t                    it;
        logic [2:0][DIV_NUM_W-1:0] sqm;
        logic [2:0][DIV_NUM_W-1:0] sqb;
        logic [2:0][WORD_BITS-1:0] mm;
    } sq_t;

    logic   a_vld_reg;
    item_t  a_reg;
    logic   b_vld_reg;
    sq_t    b_reg;
    sq_t    b_next;
    logic   c_vld_reg;
    carry_t c_reg;
    carry_t c_next;
    logic [2:0][DIV_NUM_W-1:0] c_num_reg;
    logic [2:0][DIV_NUM_W-1:0] c_num_next;
    logic [DIV_NUM_W-1:0]      c_numk_reg;
    logic [DIV_NUM_W-1:0]      c_numk_next;
    logic [RHO_W-1:0]          c_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_comb
    begin
        b_next.it = a_reg;
        b_next.mm[0] = mag(a_reg.mx);
        b_next.mm[1] = mag(a_reg.my);
        b_next.mm[2] = mag(a_reg.mz);
        b_next.sqm[0] = DIV_NUM_W'(b_next.mm[0]) * DIV_NUM_W'(b_next.mm[0]);
        b_next.sqm[1] = DIV_NUM_W'(b_next.mm[1]) * DIV_NUM_W'(b_next.mm[1]);
        b_next.sqm[2] = DIV_NUM_W'(b_next.mm[2]) * DIV_NUM_W'(b_next.mm[2]);
        b_next.sqb[0] = DIV_NUM_W'(mag(a_reg.bx)) * DIV_NUM_W'(mag(a_reg.bx));
        b_next.sqb[1] = DIV_NUM_W'(mag(a_reg.by)) * DIV_NUM_W'(mag(a_reg.by));
        b_next.sqb[2] = DIV_NUM_W'(mag(a_reg.bz)) * DIV_NUM_W'(mag(a_reg.bz));
    end

    always_comb
    begin
        logic [DIV_NUM_W-1:0] bsum;
        clip_t                pmc;
        bsum = b_reg.sqb[0] + b_reg.sqb[1] + b_reg.sqb[2];
        pmc  = clip_w(longint'(bsum >> (FRAC_BITS + 1)));
        c_numk_next = b_reg.sqm[0] + b_reg.sqm[1] + b_reg.sqm[2];
        for (int i = 0; i < 3; i++)
        begin
            c_num_next[i] = DIV_NUM_W'(b_reg.mm[i]) << FRAC_BITS;
            c_next.vel_ovf[i] = c_num_next[i][DIV_NUM_W-1:Q_BITS] >= Q_BITS'(b_reg.it.rho);
        end
        c_next.vel_neg  = {b_reg.it.mz[WORD_BITS-1], b_reg.it.my[WORD_BITS-1],
                           b_reg.it.mx[WORD_BITS-1]};
        // quotient of 2^32 or more cannot fit, flag it before the divide
        c_next.ke_ovf   = c_numk_next[DIV_NUM_W-1:Q_BITS] >= Q_BITS'(b_reg.it.rho);
        c_next.rho_zero = (b_reg.it.rho == '0);
        c_next.pm       = pmc.val;
        c_next.sat      = pmc.sat;
        c_next.en       = b_reg.it.en;
        c_next.mx       = b_reg.it.mx;
        c_next.bx       = b_reg.it.bx;
        c_next.by       = b_reg.it.by;
        c_next.bz       = b_reg.it.bz;
        c_next.last     = b_reg.it.last;
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= '{density, mom_x, mom_y, mom_z, total_energy,
                        field_x, field_y, field_z, last_cell};
        b_reg      <= b_next;
        c_reg      <= c_next;
        c_num_reg  <= c_num_next;
        c_numk_reg <= c_numk_next;
        c_den_reg  <= b_reg.it.rho;
    end

    assign out_vld = c_vld_reg;
    assign carry   = c_reg;
    assign num_u   = c_num_reg[0];
    assign num_v   = c_num_reg[1];
    assign num_w   = c_num_reg[2];
    assign num_k   = c_numk_reg;
    assign den     = c_den_reg;

endmodule

### hw/rtl/imf_div.sv
// ----------------------------------------------------------------------------
// imf_div
// Pipelined restoring divider, one quotient bit per stage. The numerator
// must give a quotient below 2^Q_BITS; the divider does not enforce this.
// ----------------------------------------------------------------------------
module imf_div
    import imf_pkg::*;
(
    input  logic                 clk,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [RHO_W-1:0]     den,
    output logic [Q_BITS-1:0]    quo
);

    logic [RHO_W-1:0]  rem_reg [Q_BITS];
    logic [Q_BITS-1:0] low_reg [Q_BITS];
    logic [Q_BITS-1:0] quo_reg [Q_BITS];
    logic [RHO_W-1:0]  den_reg [Q_BITS];

    for (genvar j = 0; j < Q_BITS; j++)
    begin : g_step
        logic [RHO_W-1:0]  rem_in;
        logic [RHO_W-1:0]  den_in;
        logic [Q_BITS-1:0] low_in;
        logic [Q_BITS-1:0] quo_in;
        logic [RHO_W:0]    trial;
        logic [RHO_W-1:0]  rem_next;
        logic [Q_BITS-1:0] quo_next;

        if (j == 0)
        begin : g_first
            assign rem_in = num[Q_BITS +: RHO_W];
            assign low_in = num[Q_BITS-1:0];
            assign quo_in = '0;
            assign den_in = den;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign low_in = low_reg[j-1];
            assign quo_in = quo_reg[j-1];
            assign den_in = den_reg[j-1];
        end

        always_comb
        begin
            trial = {rem_in, low_in[Q_BITS-1]};
            if (trial >= {1'b0, den_in})
            begin
                rem_next = RHO_W'(trial - {1'b0, den_in});
                quo_next = {quo_in[Q_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[RHO_W-1:0];
                quo_next = {quo_in[Q_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j] <= rem_next;
            low_reg[j] <= {low_in[Q_BITS-2:0], 1'b0};
            quo_reg[j] <= quo_next;
            den_reg[j] <= den_in;
        end
    end

    assign quo = quo_reg[Q_BITS-1];

endmodule

### hw/rtl/imf_flux.sv
// ----------------------------------------------------------------------------
// imf_flux
// Back end: velocity and kinetic term fix-up, pressures, products and the
// saturating flux sums, ending in the result register.
// ----------------------------------------------------------------------------
module imf_flux
    import imf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_vld,
    input  carry_t             carry,
    input  logic [Q_BITS-1:0]  quo_u,
    input  logic [Q_BITS-1:0]  quo_v,
    input  logic [Q_BITS-1:0]  quo_w,
    input  logic [Q_BITS-1:0]  quo_k,
    input  logic [GAMMA_W-1:0] gamma,
    output logic               done,
    output word_t              mass_flux,
    output word_t              xmom_flux,
    output word_t              ymom_flux,
    output word_t              zmom_flux,
    output word_t              energy_flux,
    output word_t              by_flux,
    output word_t              bz_flux,
    output logic               last_out,
    output logic               saturated
);

    typedef struct packed {
        word_t u, v, w, ke, pm, en, mx, bx, by, bz;
        logic  last, sat;
    } d_t;

    typedef struct packed {
        prod_t mxu, mxv, mxw, bxbx, bxby, bxbz, ubx, vby, wbz, uby, vbx, ubz, wbx;
        word_t inner, u, pm, en, mx, bx;
        logic  last, sat;
    } e_t;

    typedef struct packed {
        prod_t                pg;
        logic signed [PROD_W:0] xmp;
        word_t                ym, zm, fby, fbz, vdb, u, pm, en, mx, bx;
        logic                 last, sat;
    } f_t;

    typedef struct packed {
        word_t                pt;
        logic signed [PROD_W:0] xmp;
        word_t                ym, zm, fby, fbz, vdb, u, en, mx, bx;
        logic                 last, sat;
    } g_t;

    typedef struct packed {
        word_t ept, fxm, ym, zm, fby, fbz, vdb, u, mx, bx;
        logic  last, sat;
    } h_t;

    typedef struct packed {
        prod_t pe, pb;
        word_t fxm, ym, zm, fby, fbz, mx;
        logic  last, sat;
    } i_t;

    typedef struct packed {
        word_t mass, xm, ym, zm, en, fby, fbz;
        logic  last, sat;
    } o_t;

    function automatic clip_t vel_fix(input logic [Q_BITS-1:0] q, input logic ovf,
                                      input logic neg, input logic zero);
        clip_t  r;
        longint m;
        m = longint'(q);
        if (neg)
            m = -m;
        r = clip_w(m);
        if (zero)
        begin
            r.val = '0;
            r.sat = 1'b1;
        end
        else if (ovf)
        begin
            r.val = neg ? word_t'(W_MIN) : word_t'(W_MAX);
            r.sat = 1'b1;
        end
        return r;
    endfunction

    logic [6:0] vld_reg;
    d_t d_reg, d_next;
    e_t e_reg, e_next;
    f_t f_reg, f_next;
    g_t g_reg, g_next;
    h_t h_reg, h_next;
    i_t i_reg, i_next;
    o_t o_reg, o_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[5:0], in_vld};
    end

    always_comb
    begin
        clip_t cu, cv, cw;
        cu = vel_fix(quo_u, carry.vel_ovf[0], carry.vel_neg[0], carry.rho_zero);
        cv = vel_fix(quo_v, carry.vel_ovf[1], carry.vel_neg[1], carry.rho_zero);
        cw = vel_fix(quo_w, carry.vel_ovf[2], carry.vel_neg[2], carry.rho_zero);
        d_next.u = cu.val;
        d_next.v = cv.val;
        d_next.w = cw.val;
        // kinetic half term, halved after the divide
        if (carry.rho_zero)
            d_next.ke = '0;
        else if (carry.ke_ovf)
            d_next.ke = word_t'(W_MAX);
        else
            d_next.ke = {1'b0, quo_k[Q_BITS-1:1]};
        d_next.pm   = carry.pm;
        d_next.en   = carry.en;
        d_next.mx   = carry.mx;
        d_next.bx   = carry.bx;
        d_next.by   = carry.by;
        d_next.bz   = carry.bz;
        d_next.last = carry.last;
        d_next.sat  = carry.sat | cu.sat | cv.sat | cw.sat | carry.rho_zero | carry.ke_ovf;
    end

    always_comb
    begin
        clip_t ci;
        ci = clip_w(longint'(d_reg.en) - longint'(d_reg.ke) - longint'(d_reg.pm));
        e_next.mxu  = PROD_W'(fmul(d_reg.mx, d_reg.u));
        e_next.mxv  = PROD_W'(fmul(d_reg.mx, d_reg.v));
        e_next.mxw  = PROD_W'(fmul(d_reg.mx, d_reg.w));
        e_next.bxbx = PROD_W'(fmul(d_reg.bx, d_reg.bx));
        e_next.bxby = PROD_W'(fmul(d_reg.bx, d_reg.by));
        e_next.bxbz = PROD_W'(fmul(d_reg.bx, d_reg.bz));
        e_next.ubx  = PROD_W'(fmul(d_reg.u, d_reg.bx));
        e_next.vby  = PROD_W'(fmul(d_reg.v, d_reg.by));
        e_next.wbz  = PROD_W'(fmul(d_reg.w, d_reg.bz));
        e_next.uby  = PROD_W'(fmul(d_reg.u, d_reg.by));
        e_next.vbx  = PROD_W'(fmul(d_reg.v, d_reg.bx));
        e_next.ubz  = PROD_W'(fmul(d_reg.u, d_reg.bz));
        e_next.wbx  = PROD_W'(fmul(d_reg.w, d_reg.bx));
        e_next.inner = ci.val;
        e_next.u    = d_reg.u;
        e_next.pm   = d_reg.pm;
        e_next.en   = d_reg.en;
        e_next.mx   = d_reg.mx;
        e_next.bx   = d_reg.bx;
        e_next.last = d_reg.last;
        e_next.sat  = d_reg.sat | ci.sat;
    end

    always_comb
    begin
        word_t gm1;
        clip_t cym, czm, cby, cbz, cvd;
        // gamma below one gives a negative factor, used as it stands
        gm1 = word_t'(longint'(gamma) - ONE);
        cym = clip_w(longint'(e_reg.mxv) - longint'(e_reg.bxby));
        czm = clip_w(longint'(e_reg.mxw) - longint'(e_reg.bxbz));
        cby = clip_w(longint'(e_reg.uby) - longint'(e_reg.vbx));
        cbz = clip_w(longint'(e_reg.ubz) - longint'(e_reg.wbx));
        cvd = clip_w(longint'(e_reg.ubx) + longint'(e_reg.vby) + longint'(e_reg.wbz));
        f_next.pg   = PROD_W'(fmul(gm1, e_reg.inner));
        f_next.xmp  = (PROD_W+1)'(longint'(e_reg.mxu) - longint'(e_reg.bxbx));
        f_next.ym   = cym.val;
        f_next.zm   = czm.val;
        f_next.fby  = cby.val;
        f_next.fbz  = cbz.val;
        f_next.vdb  = cvd.val;
        f_next.u    = e_reg.u;
        f_next.pm   = e_reg.pm;
        f_next.en   = e_reg.en;
        f_next.mx   = e_reg.mx;
        f_next.bx   = e_reg.bx;
        f_next.last = e_reg.last;
        f_next.sat  = e_reg.sat | cym.sat | czm.sat | cby.sat | cbz.sat | cvd.sat;
    end

    always_comb
    begin
        clip_t cpg, cpt;
        cpg = clip_w(longint'(f_reg.pg));
        cpt = clip_w(longint'(cpg.val) + longint'(f_reg.pm));
        g_next.pt   = cpt.val;
        g_next.xmp  = f_reg.xmp;
        g_next.ym   = f_reg.ym;
        g_next.zm   = f_reg.zm;
        g_next.fby  = f_reg.fby;
        g_next.fbz  = f_reg.fbz;
        g_next.vdb  = f_reg.vdb;
        g_next.u    = f_reg.u;
        g_next.en   = f_reg.en;
        g_next.mx   = f_reg.mx;
        g_next.bx   = f_reg.bx;
        g_next.last = f_reg.last;
        g_next.sat  = f_reg.sat | cpg.sat | cpt.sat;
    end

    always_comb
    begin
        clip_t cep, cxm;
        cep = clip_w(longint'(g_reg.en) + longint'(g_reg.pt));
        cxm = clip_w(longint'(g_reg.xmp) + longint'(g_reg.pt));
        h_next.ept  = cep.val;
        h_next.fxm  = cxm.val;
        h_next.ym   = g_reg.ym;
        h_next.zm   = g_reg.zm;
        h_next.fby  = g_reg.fby;
        h_next.fbz  = g_reg.fbz;
        h_next.vdb  = g_reg.vdb;
        h_next.u    = g_reg.u;
        h_next.mx   = g_reg.mx;
        h_next.bx   = g_reg.bx;
        h_next.last = g_reg.last;
        h_next.sat  = g_reg.sat | cep.sat | cxm.sat;
    end

    always_comb
    begin
        i_next.pe   = PROD_W'(fmul(h_reg.u, h_reg.ept));
        i_next.pb   = PROD_W'(fmul(h_reg.bx, h_reg.vdb));
        i_next.fxm  = h_reg.fxm;
        i_next.ym   = h_reg.ym;
        i_next.zm   = h_reg.zm;
        i_next.fby  = h_reg.fby;
        i_next.fbz  = h_reg.fbz;
        i_next.mx   = h_reg.mx;
        i_next.last = h_reg.last;
        i_next.sat  = h_reg.sat;
    end

    always_comb
    begin
        clip_t cen;
        cen = clip_w(longint'(i_reg.pe) - longint'(i_reg.pb));
        o_next.mass = i_reg.mx;
        o_next.xm   = i_reg.fxm;
        o_next.ym   = i_reg.ym;
        o_next.zm   = i_reg.zm;
        o_next.en   = cen.val;
        o_next.fby  = i_reg.fby;
        o_next.fbz  = i_reg.fbz;
        o_next.last = i_reg.last;
        o_next.sat  = i_reg.sat | cen.sat;
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
        e_reg <= e_next;
        f_reg <= f_next;
        g_reg <= g_next;
        h_reg <= h_next;
        i_reg <= i_next;
        o_reg <= o_next;
    end

    assign done        = vld_reg[6];
    assign mass_flux   = o_reg.mass;
    assign xmom_flux   = o_reg.xm;
    assign ymom_flux   = o_reg.ym;
    assign zmom_flux   = o_reg.zm;
    assign energy_flux = o_reg.en;
    assign by_flux     = o_reg.fby;
    assign bz_flux     = o_reg.fbz;
    assign last_out    = o_reg.last;
    assign saturated   = o_reg.sat;

endmodule

### hw/rtl/ideal_mhd_x_flux.sv
// ----------------------------------------------------------------------------
// ideal_mhd_x_flux
// Ideal-MHD x-direction flux of one cell from its conserved variables.
// ----------------------------------------------------------------------------
// One cell is taken every clock cycle; busy is never raised. Each result
// appears on the flux ports for one cycle with done high, after the prep
// registers, the four 32-stage quotient pipelines (three velocities and the
// kinetic term, one quotient bit per stage) and the back-end registers, in
// the order the cells came in; the receiver must take every result.
module ideal_mhd_x_flux
    import imf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [RHO_W-1:0]   density,
    input  word_t              mom_x,
    input  word_t              mom_y,
    input  word_t              mom_z,
    input  word_t              total_energy,
    input  word_t              field_x,
    input  word_t              field_y,
    input  word_t              field_z,
    input  logic               last_cell,
    input  logic               cfg_wr_en,
    input  logic [GAMMA_W-1:0] cfg_wr_data,
    output logic               done,
    output word_t              mass_flux,
    output word_t              xmom_flux,
    output word_t              ymom_flux,
    output word_t              zmom_flux,
    output word_t              energy_flux,
    output word_t              by_flux,
    output word_t              bz_flux,
    output logic               last_out,
    output logic               saturated
);

    logic [GAMMA_W-1:0]   gamma_reg;
    logic                 pre_vld;
    carry_t               pre_carry;
    logic [DIV_NUM_W-1:0] num_u, num_v, num_w, num_k;
    logic [RHO_W-1:0]     den;
    logic [Q_BITS-1:0]    quo_u, quo_v, quo_w, quo_k;
    logic                 dly_vld_reg   [Q_BITS];
    carry_t               dly_carry_reg [Q_BITS];

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gamma_reg <= GAMMA_RESET;
        else if (cfg_wr_en)
            gamma_reg <= cfg_wr_data;
    end

    imf_prep u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_vld       (start && !busy),
        .density      (density),
        .mom_x        (mom_x),
        .mom_y        (mom_y),
        .mom_z        (mom_z),
        .total_energy (total_energy),
        .field_x      (field_x),
        .field_y      (field_y),
        .field_z      (field_z),
        .last_cell    (last_cell),
        .out_vld      (pre_vld),
        .carry        (pre_carry),
        .num_u        (num_u),
        .num_v        (num_v),
        .num_w        (num_w),
        .num_k        (num_k),
        .den          (den)
    );

    imf_div u_div_u (.clk(clk), .num(num_u), .den(den), .quo(quo_u));
    imf_div u_div_v (.clk(clk), .num(num_v), .den(den), .quo(quo_v));
    imf_div u_div_w (.clk(clk), .num(num_w), .den(den), .quo(quo_w));
    imf_div u_div_k (.clk(clk), .num(num_k), .den(den), .quo(quo_k));

    // side data kept in step with the quotient pipelines
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < Q_BITS; i++)
                dly_vld_reg[i] <= 1'b0;
        end
        else
        begin
            dly_vld_reg[0] <= pre_vld;
            for (int i = 1; i < Q_BITS; i++)
                dly_vld_reg[i] <= dly_vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        dly_carry_reg[0] <= pre_carry;
        for (int i = 1; i < Q_BITS; i++)
            dly_carry_reg[i] <= dly_carry_reg[i-1];
    end

    imf_flux u_flux (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_vld      (dly_vld_reg[Q_BITS-1]),
        .carry       (dly_carry_reg[Q_BITS-1]),
        .quo_u       (quo_u),
        .quo_v       (quo_v),
        .quo_w       (quo_w),
        .quo_k       (quo_k),
        .gamma       (gamma_reg),
        .done        (done),
        .mass_flux   (mass_flux),
        .xmom_flux   (xmom_flux),
        .ymom_flux   (ymom_flux),
        .zmom_flux   (zmom_flux),
        .energy_flux (energy_flux),
        .by_flux     (by_flux),
        .bz_flux     (bz_flux),
        .last_out    (last_out),
        .saturated   (saturated)
    );

endmodule

### hw/rtl/imf_chk.sv
// ----------------------------------------------------------------------------
// imf_chk
// Port-level checks of the flux block: fixed latency and pass-through
// fields, attached to the top level by bind.
// ----------------------------------------------------------------------------
module imf_chk
    import imf_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  start,
    input logic  busy,
    input logic  last_cell,
    input word_t mom_x,
    input logic  done,
    input logic  last_out,
    input word_t mass_flux
);

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("item taken but no result after the pipeline latency");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching item");

    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (last_out == $past(last_cell, LATENCY)))
        else $error("last mark does not match its item");

    a_mass_flux: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (mass_flux == $past(mom_x, LATENCY)))
        else $error("mass flux differs from x momentum of its item");

endmodule

bind ideal_mhd_x_flux imf_chk u_imf_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .last_cell (last_cell),
    .mom_x     (mom_x),
    .done      (done),
    .last_out  (last_out),
    .mass_flux (mass_flux)
);

### tb/sv/imf_flux_checker.sv
// ----------------------------------------------------------------------------
// imf_flux_checker
// Watches the cell and flux channels of the x-direction MHD flux block,
// predicts each flux result from the accepted cell and compares in order.
// ----------------------------------------------------------------------------
module imf_flux_checker
    import imf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [RHO_W-1:0]   density,
    input  word_t              mom_x,
    input  word_t              mom_y,
    input  word_t              mom_z,
    input  word_t              total_energy,
    input  word_t              field_x,
    input  word_t              field_y,
    input  word_t              field_z,
    input  logic               last_cell,
    input  logic               cfg_wr_en,
    input  logic [GAMMA_W-1:0] cfg_wr_data,
    input  logic               done,
    input  word_t              mass_flux,
    input  word_t              xmom_flux,
    input  word_t              ymom_flux,
    input  word_t              zmom_flux,
    input  word_t              energy_flux,
    input  word_t              by_flux,
    input  word_t              bz_flux,
    input  logic               last_out,
    input  logic               saturated,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        word_t mass;
        word_t xmom;
        word_t ymom;
        word_t zmom;
        word_t energy;
        word_t by;
        word_t bz;
        logic  last;
        logic  sat;
    } flux_t;

    flux_t                flux_q[$];
    logic [GAMMA_W-1:0]   gamma_q;

    function automatic longint sat_word(input longint x, inout logic flag);
        if (x > W_MAX) begin
            flag = 1'b1;
            return W_MAX;
        end
        if (x < W_MIN) begin
            flag = 1'b1;
            return W_MIN;
        end
        return x;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        longint p;
        p = a * b;
        return p >>> FRAC_BITS;
    endfunction

    function automatic longint unsigned sqr(input longint a);
        longint unsigned m;
        m = (a < 0) ? longint'(-a) : a;
        return m * m;
    endfunction

    function automatic flux_t predict_flux(input logic [RHO_W-1:0] rho_in,
                                           input word_t mxi, input word_t myi,
                                           input word_t mzi, input word_t eni,
                                           input word_t bxi, input word_t byi,
                                           input word_t bzi, input logic lst,
                                           input logic [GAMMA_W-1:0] gam);
        flux_t r;
        logic sat;
        longint rho, mx, my, mz, en, bx, by, bz;
        longint u, v, w, ke, pm, gm1, inner, pgas, pt, ept, vdb;
        longint unsigned s, k, bs;
        sat = 1'b0;
        rho = longint'(rho_in);
        mx = mxi; my = myi; mz = mzi; en = eni;
        bx = bxi; by = byi; bz = bzi;
        u = 0; v = 0; w = 0; ke = 0;
        if (rho == 0) begin
            sat = 1'b1;
        end else begin
            u = sat_word((mx * ONE) / rho, sat);
            v = sat_word((my * ONE) / rho, sat);
            w = sat_word((mz * ONE) / rho, sat);
            s = sqr(mx) + sqr(my) + sqr(mz);
            k = (s / longint'(rho)) >> 1;
            if (k > W_MAX) begin
                k = W_MAX;
                sat = 1'b1;
            end
            ke = longint'(k);
        end
        bs = (sqr(bx) + sqr(by) + sqr(bz)) >> (FRAC_BITS + 1);
        if (bs > W_MAX) begin
            bs = W_MAX;
            sat = 1'b1;
        end
        pm = longint'(bs);
        gm1 = longint'(gam) - ONE;
        inner = sat_word(en - ke - pm, sat);
        pgas = sat_word(qmul(gm1, inner), sat);
        pt = sat_word(pgas + pm, sat);
        r.mass = word_t'(sat_word(mx, sat));
        r.xmom = word_t'(sat_word(qmul(mx, u) - qmul(bx, bx) + pt, sat));
        r.ymom = word_t'(sat_word(qmul(mx, v) - qmul(bx, by), sat));
        r.zmom = word_t'(sat_word(qmul(mx, w) - qmul(bx, bz), sat));
        ept = sat_word(en + pt, sat);
        vdb = sat_word(qmul(u, bx) + qmul(v, by) + qmul(w, bz), sat);
        r.energy = word_t'(sat_word(qmul(u, ept) - qmul(bx, vdb), sat));
        r.by = word_t'(sat_word(qmul(u, by) - qmul(v, bx), sat));
        r.bz = word_t'(sat_word(qmul(u, bz) - qmul(w, bx), sat));
        r.last = lst;
        r.sat = sat;
        return r;
    endfunction

    task automatic cmp(input string what, input longint exp_v, input longint got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s expected %0d got %0d", $time, what, exp_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        flux_t e;
        if (!rst_n) begin
            gamma_q = GAMMA_RESET;
            flux_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_wr_en)
                gamma_q = cfg_wr_data;
            if (start && !busy)
                flux_q.push_back(predict_flux(density, mom_x, mom_y, mom_z,
                                              total_energy, field_x, field_y,
                                              field_z, last_cell, gamma_q));
            if (done) begin
                if (flux_q.size() == 0) begin
                    $display("%0t: flux result with none expected", $time);
                    fail_count++;
                end else begin
                    e = flux_q.pop_front();
                    cmp("mass_flux", e.mass, mass_flux);
                    cmp("xmom_flux", e.xmom, xmom_flux);
                    cmp("ymom_flux", e.ymom, ymom_flux);
                    cmp("zmom_flux", e.zmom, zmom_flux);
                    cmp("energy_flux", e.energy, energy_flux);
                    cmp("by_flux", e.by, by_flux);
                    cmp("bz_flux", e.bz, bz_flux);
                    cmp("last_out", e.last, last_out);
                    cmp("saturated", e.sat, saturated);
                end
            end
        end
        pending = flux_q.size();
    end

endmodule

### tb/sv/tb_ideal_mhd_x_flux.sv
// ----------------------------------------------------------------------------
// tb_ideal_mhd_x_flux
// Drives cells into the x-direction MHD flux block under several gamma
// settings and sender idle patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_ideal_mhd_x_flux;
    import imf_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [RHO_W-1:0]   density = '0;
    word_t              mom_x = '0;
    word_t              mom_y = '0;
    word_t              mom_z = '0;
    word_t              total_energy = '0;
    word_t              field_x = '0;
    word_t              field_y = '0;
    word_t              field_z = '0;
    logic               last_cell = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [GAMMA_W-1:0] cfg_wr_data = '0;
    logic               done;
    word_t              mass_flux, xmom_flux, ymom_flux, zmom_flux;
    word_t              energy_flux, by_flux, bz_flux;
    logic               last_out, saturated;
    int                 fail_count;
    int                 pending;
    int                 idle_pct;

    localparam logic [RHO_W-1:0] RHO_ONE = RHO_W'(ONE);
    localparam word_t W_ONE = word_t'(ONE);
    localparam word_t W_HI  = word_t'(W_MAX);
    localparam word_t W_LO  = word_t'(W_MIN);

    always #5 clk = ~clk;

    ideal_mhd_x_flux u_dut (.*);

    imf_flux_checker u_chk (.*);

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_cell(input logic [RHO_W-1:0] rho, input word_t mx,
                             input word_t my, input word_t mz, input word_t en,
                             input word_t bx, input word_t by, input word_t bz,
                             input logic lst);
        while (($urandom % 100) < idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        density <= rho;
        mom_x <= mx; mom_y <= my; mom_z <= mz;
        total_energy <= en;
        field_x <= bx; field_y <= by; field_z <= bz;
        last_cell <= lst;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic set_gamma(input logic [GAMMA_W-1:0] g);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= g;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // mix of full-range, physically sized and extreme values
    function automatic word_t rand_word();
        case ($urandom_range(0, 9))
            0, 1, 2: return word_t'($urandom);
            3: return $urandom_range(0, 1) ? W_HI : W_LO;
            default: return word_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
        endcase
    endfunction

    function automatic logic [RHO_W-1:0] rand_rho();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return RHO_W'(1);
            2, 3, 4: return RHO_W'($urandom);
            default: return RHO_W'($urandom_range(1 << 12, 1 << 20));
        endcase
    endfunction

    task automatic random_cells(input int n);
        for (int i = 0; i < n; i++)
            send_cell(rand_rho(), rand_word(), rand_word(), rand_word(),
                      rand_word(), rand_word(), rand_word(), rand_word(),
                      ($urandom % 16) == 0);
    endtask

    initial begin
        idle_pct = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: zero cell, unit and extreme densities, zero density
        send_cell(RHO_ONE, '0, '0, '0, '0, '0, '0, '0, 1'b0);
        send_cell(RHO_ONE, W_ONE, word_t'(ONE / 2), word_t'(-ONE), word_t'(3 * ONE),
                  W_ONE, word_t'(-ONE), word_t'(ONE / 4), 1'b0);
        send_cell(RHO_W'(1), W_HI, W_LO, W_HI, W_HI, W_LO, W_HI, W_LO, 1'b1);
        send_cell('1, W_LO, W_HI, W_LO, W_LO, W_HI, W_LO, W_HI, 1'b0);
        send_cell('0, W_ONE, W_ONE, W_ONE, W_ONE, W_ONE, W_ONE, W_ONE, 1'b1);
        send_cell('0, '0, '0, '0, '0, '0, '0, '0, 1'b0);
        send_cell(RHO_ONE, '1, '1, '1, '1, '1, '1, '1, 1'b1);
        send_cell(RHO_W'(2 * ONE), word_t'(-ONE), word_t'(2 * ONE), word_t'(-3 * ONE),
                  word_t'(-ONE), W_HI, W_HI, W_HI, 1'b0);
        send_cell(RHO_W'(ONE / 2), word_t'(5 * ONE), '0, '0, word_t'(40 * ONE),
                  '0, '0, '0, 1'b1);
        send_cell(RHO_ONE, '0, '0, '0, W_LO, '0, '0, '0, 1'b0);
        random_cells(10);

        // gamma settings including the extremes and gamma below one
        set_gamma(GAMMA_W'(65536));
        random_cells(100);
        set_gamma(GAMMA_W'(196608));
        idle_pct = 84;
        random_cells(200);
        set_gamma('0);
        send_cell(RHO_ONE, W_ONE, W_ONE, W_ONE, word_t'(5 * ONE), W_ONE, W_ONE, W_ONE,
                  1'b0);
        send_cell(RHO_ONE, '0, '0, '0, W_HI, '0, '0, '0, 1'b1);
        random_cells(100);
        set_gamma('1);
        idle_pct = 21;
        random_cells(200);
        // hold off until every flux has come back, then resume
        drain();
        random_cells(50);
        set_gamma(GAMMA_W'($urandom_range(65536, 196608)));
        idle_pct = 0;
        random_cells(200);
        set_gamma(GAMMA_RESET);
        idle_pct = 84;
        random_cells(200);

        drain();
        repeat (LATENCY + 5) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
